@@ sv/assert_macros.svh @@
// Assertion macros shared by the sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ABS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ABS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/abs_pkg.sv @@
// Shared types, codes and helpers for the alternating-bit sender.
package abs_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_MSG   = 2'd0;
   localparam logic [1:0] REQ_ACK   = 2'd1;
   localparam logic [1:0] REQ_TIMER = 2'd2;

   // Timer commands on rsp_timer_cmd
   localparam logic [1:0] TMR_NONE  = 2'd0;
   localparam logic [1:0] TMR_START = 2'd1;
   localparam logic [1:0] TMR_STOP  = 2'd2;

   // Controls from the sequencer to the acknowledgement checker
   typedef struct packed {
      logic add;    // accepted ack byte inside the payload range
      logic last;   // that byte ends the ack run
      logic check;  // compare cycle after the run end
   } abs_ack_ctl_type;

   function automatic logic [31:0] abs_sext8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

endpackage

@@ sv/abs_payload_ram.sv @@
// Payload store: one write port, one registered read port.
module abs_payload_ram #(
   parameter int DEPTH  = 20,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/abs_ack_check.sv @@
// Acknowledgement checker: sums ack bytes and verifies checksum and ack bit.
module abs_ack_check (
   input  logic                     clock,
   input  logic                     reset,
   input  abs_pkg::abs_ack_ctl_type ctl,
   input  logic signed [7:0]        data_byte,
   input  logic [31:0]              pkt_seqnum,
   input  logic [31:0]              pkt_acknum,
   input  logic [31:0]              pkt_checksum,
   input  logic                     cur_seq,
   input  logic                     wait_ack,
   output logic                     ack_ok
);
   import abs_pkg::*;

   logic [31:0] running_ff, running_in;
   logic [31:0] pair_ff;
   logic [31:0] chk_ff;
   logic        match_ff;

   always_comb begin
      running_in = running_ff;
      if (ctl.check) begin
         running_in = '0;
      end else if (ctl.add) begin
         running_in = running_ff + abs_sext8(data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         match_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         if (ctl.last) begin
            match_ff <= wait_ack && (pkt_acknum == {31'd0, cur_seq});
         end
      end
   end

   // split the header add from the final compare
   always_ff @(posedge clock) begin
      if (ctl.last) begin
         pair_ff <= pkt_seqnum + pkt_acknum;
         chk_ff  <= pkt_checksum;
      end
   end

   assign ack_ok = ctl.check && match_ff && ((running_ff + pair_ff) == chk_ff);

endmodule

@@ sv/alternating_bit_sender.sv @@
// Alternating-bit sender top level: sequencer, payload RAM, ack checker and result register.
// Message and ack bytes are accepted while the sender is idle. A message run end starts a
// checksum sweep over the payload RAM read port (ST_SUM, then ST_SUM_END). ST_SEND then
// primes the read of the first byte, and the packet streams out from that same port in
// ST_LOAD, one result per cycle while the result register is free, PAYLOAD_BYTES results
// in all. A timer expiry while waiting for an ack replays the packet the same way without
// the sweep. An ack run end takes a compare state (ST_ACK_CHK), then ST_ACK_OUT for the
// timer-stop result when the ack is accepted. A result that waits with rsp_ready low
// holds these runs.
// req_ready is low during these runs; a waiting result never blocks input in idle.
`include "assert_macros.svh"

module alternating_bit_sender #(
   parameter int PAYLOAD_BYTES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [4:0]        req_byte_index,
   input  logic signed [7:0] req_data_byte,
   input  logic [31:0]       req_pkt_seqnum,
   input  logic [31:0]       req_pkt_acknum,
   input  logic [31:0]       req_pkt_checksum,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [7:0] rsp_out_byte,
   output logic              rsp_out_seqnum,
   output logic [31:0]       rsp_out_checksum,
   output logic              rsp_out_last,
   output logic [1:0]        rsp_timer_cmd
);
   import abs_pkg::*;

   localparam int ADDR_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int CMP_RAW = $clog2(PAYLOAD_BYTES + 1);
   localparam int CMP_W   = (CMP_RAW > 5) ? CMP_RAW : 5;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAYLOAD_BYTES - 1);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SUM     = 7'b0000010,
      ST_SUM_END = 7'b0000100,
      ST_SEND    = 7'b0001000,
      ST_LOAD    = 7'b0010000,
      ST_ACK_CHK = 7'b0100000,
      ST_ACK_OUT = 7'b1000000
   } abs_state_type;

   abs_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [31:0]     sum_ff, sum_in;
   logic [31:0]     saved_chk_ff, saved_chk_in;
   logic            seq_ff, seq_in;
   logic            wait_ack_ff, wait_ack_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] out_byte_ff;
   logic              out_seq_ff;
   logic [31:0]       out_chk_ff;
   logic              out_last_ff;
   logic [1:0]        out_tmr_ff;

   logic              acc, idx_ok, run_end, msg_wr, ack_byte, timer_hit, out_free;
   logic [CMP_W-1:0]  idx_ext;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;
   logic              load, load_ack, ack_ok;
   abs_ack_ctl_type   ack_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign idx_ext   = CMP_W'(req_byte_index);
   assign idx_ok    = idx_ext < CMP_W'(PAYLOAD_BYTES);
   assign run_end   = idx_ext == CMP_W'(PAYLOAD_BYTES - 1);
   assign msg_wr    = acc && (req_type == REQ_MSG) && idx_ok && !wait_ack_ff;
   assign ack_byte  = acc && (req_type == REQ_ACK) && idx_ok;
   assign timer_hit = acc && (req_type == REQ_TIMER) && wait_ack_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign ack_ctl.add   = ack_byte;
   assign ack_ctl.last  = ack_byte && run_end;
   assign ack_ctl.check = (state_ff == ST_ACK_CHK);

   abs_payload_ram #(
      .DEPTH  (PAYLOAD_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (msg_wr),
      .waddr (idx_ext[ADDR_W-1:0]),
      .wdata (req_data_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   abs_ack_check u_ack (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ack_ctl),
      .data_byte    (req_data_byte),
      .pkt_seqnum   (req_pkt_seqnum),
      .pkt_acknum   (req_pkt_acknum),
      .pkt_checksum (req_pkt_checksum),
      .cur_seq      (seq_ff),
      .wait_ack     (wait_ack_ff),
      .ack_ok       (ack_ok)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      saved_chk_in = saved_chk_ff;
      seq_in       = seq_ff;
      wait_ack_in  = wait_ack_ff;
      ram_re       = 1'b0;
      ram_raddr    = cnt_ff;
      load         = 1'b0;
      load_ack     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (msg_wr && run_end) begin
               sum_in   = {31'd0, seq_ff};
               state_in = ST_SUM;
            end else if (ack_byte && run_end) begin
               state_in = ST_ACK_CHK;
            end else if (timer_hit) begin
               state_in = ST_SEND;
            end
         end
         ST_SUM: begin
            // read data is registered, so it lags the address
            ram_re = 1'b1;
            if (cnt_ff != '0) begin
               sum_in = sum_ff + abs_sext8(ram_rdata);
            end
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_SUM_END;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_SUM_END: begin
            saved_chk_in = sum_ff + abs_sext8(ram_rdata);
            wait_ack_in  = 1'b1;
            cnt_in       = '0;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               load = 1'b1;
               if (cnt_ff == LAST_ADDR) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = cnt_ff + ADDR_W'(1);
                  cnt_in    = cnt_ff + ADDR_W'(1);
               end
            end
         end
         ST_ACK_CHK: begin
            if (ack_ok) begin
               wait_ack_in = 1'b0;
               seq_in      = !seq_ff;
               state_in    = ST_ACK_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACK_OUT: begin
            if (out_free) begin
               load_ack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load || load_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         seq_ff       <= 1'b0;
         wait_ack_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         seq_ff       <= seq_in;
         wait_ack_ff  <= wait_ack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      saved_chk_ff <= saved_chk_in;
      if (load) begin
         out_byte_ff <= ram_rdata;
         out_seq_ff  <= seq_ff;
         out_chk_ff  <= saved_chk_ff;
         out_last_ff <= (cnt_ff == LAST_ADDR);
         out_tmr_ff  <= (cnt_ff == LAST_ADDR) ? TMR_START : TMR_NONE;
      end else if (load_ack) begin
         // seq already toggled: report the acknowledged bit
         out_byte_ff <= '0;
         out_seq_ff  <= !seq_ff;
         out_chk_ff  <= '0;
         out_last_ff <= 1'b1;
         out_tmr_ff  <= TMR_STOP;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_out_seqnum   = out_seq_ff;
   assign rsp_out_checksum = out_chk_ff;
   assign rsp_out_last     = out_last_ff;
   assign rsp_timer_cmd    = out_tmr_ff;

   `ABS_ASSERT(a_no_rw_clash, clock, reset, !(msg_wr && ram_re), "payload RAM read and written together")
   `ABS_ASSERT(a_send_waits_ack, clock, reset, (state_ff == ST_SEND) |-> wait_ack_ff, "packet sent while not awaiting ack")
   `ABS_ASSERT(a_ack_wait_entry, clock, reset, $rose(wait_ack_ff) |-> $past(state_ff) == ST_SUM_END, "ack wait entered outside checksum sweep")
   `ABS_ASSERT(a_load_free, clock, reset, (load || load_ack) |-> out_free, "result register overwritten")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the alternating-bit sender: directed runs, then random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import abs_pkg::*;

   localparam int NBYTES = 20;
   localparam int LIVE_ITEMS = 300;
   localparam int STALL_LIMIT = 1000;
   localparam int FROM_MODEL = -1;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic [1:0]        kind;
      logic [4:0]        index;
      logic signed [7:0] data;
      logic [31:0]       seqnum;
      logic [31:0]       acknum;
      logic [31:0]       checksum;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        seq;
      logic [31:0] checksum;
      logic        last;
      logic [1:0]  tmr;
   } pkt_word_type;

   // one row is a run of consecutive byte indices; n_typed of 0 or 1 is typed in here
   typedef struct {
      logic [1:0]   kind;
      int           first;
      int           count;
      int           base;
      int           step;
      logic [31:0]  seqnum;
      logic [31:0]  acknum;
      logic [31:0]  chk_err;
      int           n_typed;
      pkt_word_type typed;
   } plan_row_type;

   localparam pkt_word_type NO_WORD   = '0;
   localparam pkt_word_type STOP_SEQ0 = '{8'h00, 1'b0, 32'h0, 1'b1, TMR_STOP};
   localparam pkt_word_type STOP_SEQ1 = '{8'h00, 1'b1, 32'h0, 1'b1, TMR_STOP};

   plan_row_type plan [19] = '{
      '{REQ_TIMER, 0, 1, 0, 0, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_SPARE, 19, 1, -1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 0, NO_WORD},
      '{REQ_MSG, 20, 1, 5, 0, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_MSG, 31, 1, 127, 0, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_ACK, 0, 20, 3, 7, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_MSG, 0, 20, -128, 13, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD},
      '{REQ_MSG, 19, 1, 127, 0, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_ACK, 0, 20, 1, 1, 32'h5, 32'h0, 32'h1, 0, NO_WORD},
      '{REQ_TIMER, 0, 1, 0, 0, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD},
      '{REQ_ACK, 0, 20, -50, 9, 32'h0, 32'h1, 32'h0, 0, NO_WORD},
      '{REQ_ACK, 0, 20, 100, -3, 32'hFFFFFFFF, 32'h0, 32'h0, 1, STOP_SEQ0},
      '{REQ_TIMER, 0, 1, 0, 0, 32'h0, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_MSG, 0, 20, 127, 0, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD},
      '{REQ_ACK, 10, 10, -128, 0, 32'h80000000, 32'h0, 32'h0, 0, NO_WORD},
      '{REQ_ACK, 19, 1, 0, 0, 32'h0, 32'hFFFFFFFF, 32'h0, 0, NO_WORD},
      '{REQ_ACK, 0, 20, 127, 0, 32'h7FFFFFFF, 32'h1, 32'h0, 1, STOP_SEQ1},
      '{REQ_MSG, 0, 20, -128, 0, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD},
      '{REQ_TIMER, 7, 1, 0, 0, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD},
      '{REQ_ACK, 19, 1, -1, 0, 32'h0, 32'h0, 32'h0, 1, STOP_SEQ0}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_type;
   logic [4:0]        req_byte_index;
   logic signed [7:0] req_data_byte;
   logic [31:0]       req_pkt_seqnum;
   logic [31:0]       req_pkt_acknum;
   logic [31:0]       req_pkt_checksum;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [7:0] rsp_out_byte;
   logic              rsp_out_seqnum;
   logic [31:0]       rsp_out_checksum;
   logic              rsp_out_last;
   logic [1:0]        rsp_timer_cmd;

   // sender state as predicted
   logic              tx_seq;
   logic              awaiting_ack;
   logic signed [7:0] msg_store [NBYTES];
   logic [31:0]       ack_sum;
   logic [31:0]       sent_checksum;
   pkt_word_type      tx_words [NBYTES];
   int                tx_count;

   pkt_word_type awaited_words [$];
   int           mismatches;
   int           live_items;
   int           stall_cycles;
   bit           quiet;

   alternating_bit_sender #(.PAYLOAD_BYTES(NBYTES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_byte_index   (req_byte_index),
      .req_data_byte    (req_data_byte),
      .req_pkt_seqnum   (req_pkt_seqnum),
      .req_pkt_acknum   (req_pkt_acknum),
      .req_pkt_checksum (req_pkt_checksum),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_seqnum   (rsp_out_seqnum),
      .rsp_out_checksum (rsp_out_checksum),
      .rsp_out_last     (rsp_out_last),
      .rsp_timer_cmd    (rsp_timer_cmd)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void emit_packet();
      for (int k = 0; k < NBYTES; k++) begin
         tx_words[k] = '{data: msg_store[k], seq: tx_seq, checksum: sent_checksum,
                         last: (k == NBYTES - 1),
                         tmr: (k == NBYTES - 1) ? TMR_START : TMR_NONE};
      end
      tx_count = NBYTES;
   endfunction

   // advances the predicted sender by one transaction; results land in tx_words
   function automatic void sender_step(input req_item_type it);
      logic [31:0] total;
      int sx;
      tx_count = 0;
      if (it.kind == REQ_TIMER) begin
         if (awaiting_ack) emit_packet();
         return;
      end
      if (it.kind == REQ_SPARE || it.index >= NBYTES) return;
      if (it.kind == REQ_MSG) begin
         if (awaiting_ack) return;
         msg_store[it.index] = it.data;
         if (it.index != NBYTES - 1) return;
         total = {31'd0, tx_seq};
         for (int k = 0; k < NBYTES; k++) begin
            sx = msg_store[k];
            total += sx;
         end
         sent_checksum = total;
         awaiting_ack = 1'b1;
         emit_packet();
         return;
      end
      sx = it.data;
      ack_sum += sx;
      if (it.index != NBYTES - 1) return;
      total = ack_sum + it.seqnum + it.acknum;
      ack_sum = '0;
      if (!awaiting_ack || total != it.checksum || it.acknum != {31'd0, tx_seq}) return;
      tx_words[0] = '{data: 8'h00, seq: tx_seq, checksum: 32'h0, last: 1'b1, tmr: TMR_STOP};
      tx_count = 1;
      awaiting_ack = 1'b0;
      tx_seq = ~tx_seq;
   endfunction

   task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // entered and left at a falling edge
   task automatic send_item(input req_item_type it, input int n_typed,
                            input pkt_word_type typed);
      if (it.kind == REQ_TIMER ? awaiting_ack :
          (it.kind != REQ_SPARE && it.index < NBYTES && !(it.kind == REQ_MSG && awaiting_ack)))
         live_items++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= it.kind;
      req_byte_index   <= it.index;
      req_data_byte    <= it.data;
      req_pkt_seqnum   <= it.seqnum;
      req_pkt_acknum   <= it.acknum;
      req_pkt_checksum <= it.checksum;
      do @(posedge clock); while (!req_ready);
      sender_step(it);
      if (n_typed == FROM_MODEL) begin
         for (int k = 0; k < tx_count; k++) awaited_words.push_back(tx_words[k]);
      end else if (n_typed == 1) begin
         awaited_words.push_back(typed);
      end
      @(negedge clock);
   endtask

   // a run of consecutive indices; the ack checksum on the closing byte is made good
   // and then offset by chk_err
   task automatic drive_run(input logic [1:0] kind, input int first, input int count,
                            input int base, input int step, input bit rnd,
                            input logic [31:0] seqnum, input logic [31:0] acknum,
                            input logic [31:0] chk_err, input int n_typed,
                            input pkt_word_type typed);
      req_item_type it;
      int sx;
      for (int k = 0; k < count; k++) begin
         it.kind   = kind;
         it.index  = 5'(first + k);
         it.data   = rnd ? 8'($urandom()) : 8'(base + k * step);
         it.seqnum = seqnum;
         it.acknum = acknum;
         sx = it.data;
         if (k == count - 1)
            it.checksum = ack_sum + sx + seqnum + acknum + chk_err;
         else
            it.checksum = $urandom();
         if (k == count - 1 || n_typed == FROM_MODEL)
            send_item(it, n_typed, typed);
         else
            send_item(it, 0, typed);
      end
   endtask

   always @(posedge clock) begin
      pkt_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            flag("result with none awaited, byte", rsp_out_byte, 32'h0);
         end else begin
            w = awaited_words.pop_front();
            if (rsp_out_byte !== w.data) flag("out_byte", rsp_out_byte, w.data);
            if (rsp_out_seqnum !== w.seq) flag("out_seqnum", rsp_out_seqnum, w.seq);
            if (rsp_out_checksum !== w.checksum)
               flag("out_checksum", rsp_out_checksum, w.checksum);
            if (rsp_out_last !== w.last) flag("out_last", rsp_out_last, w.last);
            if (rsp_timer_cmd !== w.tmr) flag("timer_cmd", rsp_timer_cmd, w.tmr);
         end
      end
   end

   // stall watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int pick;
      int first;
      logic [31:0] acknum;
      logic [31:0] chk_err;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_MSG;
      req_byte_index   = '0;
      req_data_byte    = '0;
      req_pkt_seqnum   = '0;
      req_pkt_acknum   = '0;
      req_pkt_checksum = '0;
      rsp_ready        = 1'b0;
      stall_cycles     = 0;
      mismatches       = 0;
      live_items       = 0;
      quiet            = 1'b0;
      tx_seq           = 1'b0;
      awaiting_ack     = 1'b0;
      ack_sum          = '0;
      sent_checksum    = '0;
      foreach (msg_store[k]) msg_store[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         quiet = ($urandom_range(0, 3) == 0);
         drive_run(plan[r].kind, plan[r].first, plan[r].count, plan[r].base, plan[r].step,
                   1'b0, plan[r].seqnum, plan[r].acknum, plan[r].chk_err,
                   plan[r].n_typed, plan[r].typed);
      end

      // random traffic tops the directed part up to the item count
      while (live_items < LIVE_ITEMS) begin
         // the tail of the run goes without idling
         quiet = (live_items >= LIVE_ITEMS - 40) || ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         first = ($urandom_range(0, 4) == 0) ? $urandom_range(1, NBYTES - 1) : 0;
         if (pick < 10) begin
            drive_run(2'($urandom_range(0, 3)), $urandom_range(0, 31), 1, 0, 0, 1'b1,
                      $urandom(), $urandom(), $urandom(), FROM_MODEL, NO_WORD);
         end else if (!awaiting_ack) begin
            if (pick < 22)
               drive_run(REQ_ACK, first, NBYTES - first, 0, 0, 1'b1, $urandom(),
                         {31'd0, tx_seq}, 32'h0, FROM_MODEL, NO_WORD);
            else if (pick < 30)
               drive_run(REQ_MSG, first, NBYTES - first, $urandom_range(0, 1) ? -128 : 127,
                         0, 1'b0, 32'h0, 32'h0, 32'h0, FROM_MODEL, NO_WORD);
            else
               drive_run(REQ_MSG, first, NBYTES - first, 0, 0, 1'b1, $urandom(),
                         $urandom(), 32'h0, FROM_MODEL, NO_WORD);
         end else begin
            if (pick < 40) begin
               drive_run(REQ_TIMER, $urandom_range(0, 31), 1, 0, 0, 1'b1, $urandom(),
                         $urandom(), $urandom(), FROM_MODEL, NO_WORD);
            end else if (pick < 80) begin
               drive_run(REQ_ACK, first, NBYTES - first, 0, 0, 1'b1, $urandom(),
                         {31'd0, tx_seq}, 32'h0, FROM_MODEL, NO_WORD);
            end else begin
               // broken ack: either the wrong ack field or one flipped checksum bit
               if ($urandom_range(0, 1) == 0) begin
                  acknum  = $urandom_range(0, 1) ? {31'd0, ~tx_seq} : $urandom();
                  chk_err = 32'h0;
               end else begin
                  acknum  = {31'd0, tx_seq};
                  chk_err = 32'd1 << $urandom_range(0, 31);
               end
               drive_run(REQ_ACK, first, NBYTES - first, 0, 0, 1'b1, $urandom(),
                         acknum, chk_err, FROM_MODEL, NO_WORD);
            end
         end
      end
      req_valid <= 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (3 * NBYTES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ alternating_bit_sender.f @@
+incdir+sv
sv/abs_pkg.sv
sv/abs_payload_ram.sv
sv/abs_ack_check.sv
sv/alternating_bit_sender.sv
bench/testbench.sv
